[src/ffca_pkg.sv]
// shared types and constants of the first-fit contiguous allocator
package ffca_pkg;

  localparam int UNITS   = 1024;
  localparam int VAL_W   = 11;
  localparam int ADDR_W  = $clog2(UNITS);
  localparam int ENTRY_W = 2 * VAL_W;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_NEW   = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_GET   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_ctl_t;

endpackage

[src/ffca_list_mem.sv]
// block list memory: one entry holds the start and end unit of a block
module ffca_list_mem (
  input  logic                       clk,
  input  ffca_pkg::mem_ctl_t         ctl,
  output logic [ffca_pkg::ENTRY_W-1:0] rd_data
);

  logic [ffca_pkg::ENTRY_W-1:0] mem [ffca_pkg::UNITS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data <= mem[ctl.rd_addr];
  end

endmodule

[src/first_fit_contiguous_allocator_unit.sv]
// top level of the first-fit contiguous allocator
// Allocator over units 1..pool_size, kept as a list of blocks sorted by
// start unit in a single-port-write, registered-read memory.
// Input channel: in_tuser is the command (reset, new, free, get), in_tdata
// carries the request value (length, unit or block index).
// Output channel: one result per request; out_tuser is the status
// (0 accepted, 1 rejected), out_tdata the start and end unit.
// One request is worked at a time. The free runs are the gaps between
// listed blocks, so new and free walk the list from the front, with a
// read and a check per block visited, then move the tail of the list by
// one entry, with a read and a write per entry moved. A request takes
// longer the more blocks are listed; the memory read port is the limit.
// Reset empties the list and sets pool_size to 1024; a write on
// cfg_wr_en, taken only while idle, sets pool_size (0 gives 1, above
// 1024 gives 1024) and also empties the list. No clearing pass is needed.
// A finished result waits in the output register while the receiver
// stalls; the next request is taken meanwhile but its result waits for
// the register to drain.
module first_fit_contiguous_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,  // pool_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // request_value [10:0], zero pad
  input  logic [1:0]  in_tuser,     // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // start_unit [10:0], end_unit [21:11], zero pad
  output logic        out_tuser     // status
);

  localparam int VW = ffca_pkg::VAL_W;
  localparam int AW = ffca_pkg::ADDR_W;

  ffca_pkg::state_t state_r, state_nxt;
  ffca_pkg::cmd_t   op_r, op_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [VW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] prev_r, prev_nxt;
  logic [VW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] pool_r, pool_nxt;
  logic [VW-1:0] shift_r, shift_nxt;
  logic          rej_r, rej_nxt;
  logic [VW-1:0] rs_r, rs_nxt;
  logic [VW-1:0] re_r, re_nxt;
  logic          ov_r, ov_nxt;
  logic          ost_r, ost_nxt;
  logic [VW-1:0] os_r, os_nxt;
  logic [VW-1:0] oe_r, oe_nxt;

  ffca_pkg::mem_ctl_t ctl;
  logic [ffca_pkg::ENTRY_W-1:0] rd_data;
  logic [VW-1:0] d_start, d_end, gap;
  logic          accept, deliver;

  assign d_start = rd_data[VW-1:0];
  assign d_end   = rd_data[2*VW-1:VW];
  assign gap     = d_start - prev_r - VW'(1);
  assign accept  = in_tvalid && in_tready;
  assign deliver = (state_r == ffca_pkg::ST_DONE) && (!ov_r || out_tready);

  assign in_tready  = (state_r == ffca_pkg::ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {2'b00, oe_r, os_r};

  ffca_list_mem u_mem (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffca_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (ffca_pkg::cmd_t'(in_tuser))
            ffca_pkg::CMD_RESET: state_nxt = ffca_pkg::ST_DONE;
            ffca_pkg::CMD_NEW:   state_nxt = (in_tdata[VW-1:0] == '0) ?
                                             ffca_pkg::ST_DONE : ffca_pkg::ST_READ;
            ffca_pkg::CMD_FREE:  state_nxt = ffca_pkg::ST_READ;
            ffca_pkg::CMD_GET:   state_nxt = (in_tdata[VW-1:0] == '0 ||
                                              in_tdata[VW-1:0] > cnt_r) ?
                                             ffca_pkg::ST_DONE : ffca_pkg::ST_READ;
            default:             state_nxt = ffca_pkg::ST_DONE;
          endcase
        end
      end
      ffca_pkg::ST_READ: begin
        if (op_r != ffca_pkg::CMD_GET && idx_r == cnt_r) begin
          if (op_r == ffca_pkg::CMD_NEW && (pool_r - prev_r) >= val_r) begin
            state_nxt = ffca_pkg::ST_SHIFT_RD;
          end else begin
            state_nxt = ffca_pkg::ST_DONE;
          end
        end else begin
          state_nxt = ffca_pkg::ST_CHECK;
        end
      end
      ffca_pkg::ST_CHECK: begin
        if (op_r == ffca_pkg::CMD_NEW) begin
          state_nxt = (gap >= val_r) ? ffca_pkg::ST_SHIFT_RD : ffca_pkg::ST_READ;
        end else if (op_r == ffca_pkg::CMD_FREE) begin
          if (d_start > val_r) begin
            state_nxt = ffca_pkg::ST_DONE;
          end else if (d_end >= val_r) begin
            state_nxt = ffca_pkg::ST_SHIFT_RD;
          end else begin
            state_nxt = ffca_pkg::ST_READ;
          end
        end else begin
          state_nxt = ffca_pkg::ST_DONE;
        end
      end
      ffca_pkg::ST_SHIFT_RD: begin
        if (op_r == ffca_pkg::CMD_NEW) begin
          state_nxt = (shift_r == idx_r) ? ffca_pkg::ST_INSERT : ffca_pkg::ST_SHIFT_WR;
        end else begin
          state_nxt = (shift_r == cnt_r) ? ffca_pkg::ST_DONE : ffca_pkg::ST_SHIFT_WR;
        end
      end
      ffca_pkg::ST_SHIFT_WR: state_nxt = ffca_pkg::ST_SHIFT_RD;
      ffca_pkg::ST_INSERT:   state_nxt = ffca_pkg::ST_DONE;
      ffca_pkg::ST_DONE:     state_nxt = deliver ? ffca_pkg::ST_IDLE : ffca_pkg::ST_DONE;
      default:               state_nxt = ffca_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt    = op_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    pool_nxt  = pool_r;
    shift_nxt = shift_r;
    rej_nxt   = rej_r;
    rs_nxt    = rs_r;
    re_nxt    = re_r;
    ov_nxt    = ov_r;
    ost_nxt   = ost_r;
    os_nxt    = os_r;
    oe_nxt    = oe_r;
    ctl.wr_en   = 1'b0;
    ctl.wr_addr = idx_r[AW-1:0];
    ctl.wr_data = {re_r, rs_r};
    ctl.rd_addr = idx_r[AW-1:0];

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ffca_pkg::ST_IDLE: begin
        if (cfg_wr_en) begin
          if (cfg_wr_data == '0) begin
            pool_nxt = VW'(1);
          end else if (cfg_wr_data > VW'(ffca_pkg::UNITS)) begin
            pool_nxt = VW'(ffca_pkg::UNITS);
          end else begin
            pool_nxt = cfg_wr_data;
          end
          cnt_nxt = '0;
        end
        if (accept) begin
          op_nxt   = ffca_pkg::cmd_t'(in_tuser);
          val_nxt  = in_tdata[VW-1:0];
          prev_nxt = '0;
          rej_nxt  = 1'b1;
          rs_nxt   = '0;
          re_nxt   = '0;
          idx_nxt  = (ffca_pkg::cmd_t'(in_tuser) == ffca_pkg::CMD_GET) ?
                     in_tdata[VW-1:0] - VW'(1) : '0;
          if (ffca_pkg::cmd_t'(in_tuser) == ffca_pkg::CMD_RESET) begin
            cnt_nxt = '0;
            rej_nxt = 1'b0;
          end
        end
      end
      ffca_pkg::ST_READ: begin
        if (op_r == ffca_pkg::CMD_NEW && idx_r == cnt_r &&
            (pool_r - prev_r) >= val_r) begin
          rs_nxt    = prev_r + VW'(1);
          re_nxt    = prev_r + val_r;
          rej_nxt   = 1'b0;
          shift_nxt = cnt_r;
        end
      end
      ffca_pkg::ST_CHECK: begin
        if (op_r == ffca_pkg::CMD_NEW) begin
          if (gap >= val_r) begin
            rs_nxt    = prev_r + VW'(1);
            re_nxt    = prev_r + val_r;
            rej_nxt   = 1'b0;
            shift_nxt = cnt_r;
          end else begin
            prev_nxt = d_end;
            idx_nxt  = idx_r + VW'(1);
          end
        end else if (op_r == ffca_pkg::CMD_FREE) begin
          if (d_start <= val_r) begin
            if (d_end >= val_r) begin
              rs_nxt    = d_start;
              re_nxt    = d_end;
              rej_nxt   = 1'b0;
              shift_nxt = idx_r + VW'(1);
            end else begin
              idx_nxt = idx_r + VW'(1);
            end
          end
        end else begin
          rs_nxt  = d_start;
          re_nxt  = d_end;
          rej_nxt = 1'b0;
        end
      end
      ffca_pkg::ST_SHIFT_RD: begin
        if (op_r == ffca_pkg::CMD_NEW) begin
          ctl.rd_addr = AW'(shift_r - VW'(1));
        end else begin
          ctl.rd_addr = shift_r[AW-1:0];
          if (shift_r == cnt_r) begin
            cnt_nxt = cnt_r - VW'(1);
          end
        end
      end
      ffca_pkg::ST_SHIFT_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_data = rd_data;
        if (op_r == ffca_pkg::CMD_NEW) begin
          ctl.wr_addr = shift_r[AW-1:0];
          shift_nxt   = shift_r - VW'(1);
        end else begin
          ctl.wr_addr = AW'(shift_r - VW'(1));
          shift_nxt   = shift_r + VW'(1);
        end
      end
      ffca_pkg::ST_INSERT: begin
        ctl.wr_en = 1'b1;
        cnt_nxt   = cnt_r + VW'(1);
      end
      ffca_pkg::ST_DONE: begin
        if (deliver) begin
          ov_nxt  = 1'b1;
          ost_nxt = rej_r;
          os_nxt  = rej_r ? '0 : rs_r;
          oe_nxt  = rej_r ? '0 : re_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffca_pkg::ST_IDLE;
      cnt_r   <= '0;
      pool_r  <= VW'(ffca_pkg::UNITS);
      ov_r    <= 1'b0;
      op_r    <= ffca_pkg::CMD_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pool_r  <= pool_nxt;
      ov_r    <= ov_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    prev_r  <= prev_nxt;
    shift_r <= shift_nxt;
    rej_r   <= rej_nxt;
    rs_r    <= rs_nxt;
    re_r    <= re_nxt;
    ost_r   <= ost_nxt;
    os_r    <= os_nxt;
    oe_r    <= oe_nxt;
  end

endmodule

[src/ffca_checker.sv]
// port checker for the allocator, bound to the top level
module ffca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // held result stays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // rejected result carries zero units
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[21:0] == 22'd0)
    else $error("rejected result with nonzero units");

  // one request at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // accepted block never ends before it starts
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[21:11] >= out_tdata[10:0])
    else $error("block end below start");

endmodule

bind first_fit_contiguous_allocator_unit ffca_checker u_ffca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
